/* rtl/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 encoder: the byte-run
// job that travels from the classifier to the serialiser, and the UTF-8
// lead and continuation markers.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Most bytes one code unit can cause: a flushed surrogate plus a 3-byte form
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  // Top six bits of a code unit that mark surrogates
  localparam logic [5:0] SurrHiTag = 6'b110110;
  localparam logic [5:0] SurrLoTag = 6'b110111;

  // UTF-8 markers
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;

  // Offset added to a surrogate pair's payload to form the code point
  localparam logic [20:0] SuppBase = 21'h10000;

  typedef logic [7:0] utf8_byte_t;

  // One run of bytes caused by one code unit
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } job_t;

endpackage

/* rtl/utf16_to_utf8_encoder.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out.
//
// Input channel: in_valid / in_stall carry one code unit (in_code_unit) per
// item, byte order already resolved. A zero unit ends the string and yields
// a zero byte. A high surrogate is held until the next unit; a following
// low surrogate forms a 4-byte sequence, anything else flushes the held
// unit as a 3-byte form first.
// Output channel: out_valid / out_stall carry one byte (out_byte) per item;
// out_last_of_run marks the final byte caused by one code unit.
// Throughput: one byte per cycle from the serialiser while the receiver
// does not stall; a unit yields 0 to 6 bytes (at most 4 for a lone unit).
// The classifier takes one unit per cycle while the job queue has room.
// Path: a taken unit is stored as a job in the queue, and its first byte
// is then loaded into the output register.
// Reset clears the held surrogate, the queue and the output valid flag.
// When the receiver stalls, the output byte holds, the queue fills and
// in_stall rises once QUEUE_DEPTH jobs are waiting.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run
);

  logic            push_valid;
  u16u8_pkg::job_t push_job;
  logic            queue_full;
  logic            pop;
  u16u8_pkg::job_t head_job;
  logic            empty;

  // Classify units into byte runs
  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .push_valid   (push_valid),
    .push_job     (push_job),
    .queue_full   (queue_full)
  );

  // Decouple classifier from serialiser
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  // Emit bytes one at a time
  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* rtl/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks a held high surrogate and turns each unit into
// a run of up to six UTF-8 bytes for the queue.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_code_unit,
  output logic               push_valid,
  output u16u8_pkg::job_t    push_job,
  input  logic               queue_full
);

  logic        pend_r;
  logic        pend_nxt;
  logic [9:0]  held_r;
  logic [9:0]  held_nxt;

  logic        accept;
  logic        is_high;
  logic        is_low;
  logic        pair;
  logic        flush;
  logic [15:0] flush_unit;
  logic [20:0] code_point;
  logic [3:0][7:0] main_bytes;
  logic [2:0]  main_cnt;
  logic [2:0][7:0] flush_bytes;

  // Stall only while the queue has no room
  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  assign is_high    = (in_code_unit[15:10] == u16u8_pkg::SurrHiTag);
  assign is_low     = (in_code_unit[15:10] == u16u8_pkg::SurrLoTag);
  assign pair       = pend_r && is_low;
  assign flush      = pend_r && !is_low;
  assign flush_unit = {u16u8_pkg::SurrHiTag, held_r};
  assign code_point = u16u8_pkg::SuppBase + {1'b0, held_r, in_code_unit[9:0]};

  // Three-byte form of the held high surrogate
  assign flush_bytes[0] = u16u8_pkg::Lead3 | {4'b0, flush_unit[15:12]};
  assign flush_bytes[1] = u16u8_pkg::Cont  | {2'b0, flush_unit[11:6]};
  assign flush_bytes[2] = u16u8_pkg::Cont  | {2'b0, flush_unit[5:0]};

  // Classify the unit and build its own bytes
  always_comb begin
    main_bytes = '0;
    main_cnt   = 3'd0;
    priority if (pair) begin
      main_bytes[0] = u16u8_pkg::Lead4 | {5'b0, code_point[20:18]};
      main_bytes[1] = u16u8_pkg::Cont  | {2'b0, code_point[17:12]};
      main_bytes[2] = u16u8_pkg::Cont  | {2'b0, code_point[11:6]};
      main_bytes[3] = u16u8_pkg::Cont  | {2'b0, code_point[5:0]};
      main_cnt      = 3'd4;
    end else if (in_code_unit[15:7] == 9'd0) begin
      // covers the terminator too: a zero byte
      main_bytes[0] = in_code_unit[7:0];
      main_cnt      = 3'd1;
    end else if (in_code_unit[15:11] == 5'd0) begin
      main_bytes[0] = u16u8_pkg::Lead2 | {3'b0, in_code_unit[10:6]};
      main_bytes[1] = u16u8_pkg::Cont  | {2'b0, in_code_unit[5:0]};
      main_cnt      = 3'd2;
    end else if (is_high) begin
      main_cnt      = 3'd0;
    end else begin
      main_bytes[0] = u16u8_pkg::Lead3 | {4'b0, in_code_unit[15:12]};
      main_bytes[1] = u16u8_pkg::Cont  | {2'b0, in_code_unit[11:6]};
      main_bytes[2] = u16u8_pkg::Cont  | {2'b0, in_code_unit[5:0]};
      main_cnt      = 3'd3;
    end
  end

  // Place the flushed bytes ahead of the unit's own; a pair never flushes,
  // so at most three own bytes follow a flush
  always_comb begin
    push_job = '0;
    if (flush) begin
      push_job.bytes[2:0] = flush_bytes;
      push_job.bytes[5:3] = main_bytes[2:0];
    end else begin
      push_job.bytes[3:0] = main_bytes;
    end
    push_job.count = flush ? (main_cnt + 3'd3) : main_cnt;
  end

  // Hold back a high surrogate that causes no bytes
  assign push_valid = accept && (push_job.count != 3'd0);

  // Surrogate tracking
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (accept) begin
      pend_nxt = is_high;
      held_nxt = is_high ? in_code_unit[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= 10'd0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* rtl/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue
// Short first-in first-out queue of byte-run jobs between the classifier
// and the serialiser.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output u16u8_pkg::job_t head_job,
  output logic            empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u16u8_pkg::job_t store_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = store_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the job
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// Serialises the head job of the queue one byte a cycle, while the receiver
// does not stall, into an output register, marking the final byte of each run.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  u16u8_pkg::job_t head_job,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);

  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  // Load a new byte when the output register is free or being taken
  assign load    = !empty && (!valid_r || !out_stall);
  assign is_last = (idx_r == (head_job.count - 3'd1));
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = is_last ? 3'd0 : idx_r + 3'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_job.bytes[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;

endmodule
